// File: hdl/tss_pkg.sv
// Package for the Taylor series sine block: state and operand enums, the
// controller/datapath command and status structs, and fixed-point constants.
// No dependencies; imported by every other file of the block.
package tss_pkg;

    // Controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_SQ_START,
        S_SQ_WAIT,
        S_ACCUM,
        S_M1_START,
        S_M1_WAIT,
        S_M2_START,
        S_M2_WAIT,
        S_FINISH
    } t_state;

    // Operand pairs for the shared multiplier
    typedef enum logic [1:0] {
        MOP_SQUARE,     // x * x
        MOP_XSQ,        // term * x^2
        MOP_RECIP       // term * 1/((2n+2)(2n+3))
    } t_mul_op;

    typedef struct packed {
        logic    load;       // latch a new angle, clear sum and counters
        logic    mul_start;  // launch one Q.48 product
        t_mul_op mul_op;     // operand pair for that product
        logic    wr_x2;      // capture product as x^2
        logic    wr_term;    // capture product as the running term
        logic    adv_n;      // advance the term index
        logic    accum;      // add or subtract the term, count it
        logic    finish;     // round the sum into the output registers
    } t_dp_cmd;

    typedef struct packed {
        logic mul_done;      // product ready this cycle
        logic stop;          // this term ends the series
    } t_dp_status;

    localparam int FRAC_W      = 48;
    localparam int IDX_W       = 5;
    localparam int RECIP_DEPTH = 32;
    localparam int THR_W       = 31;

    localparam logic signed [31:0] ANGLE_LIMIT = 32'sd1686629713;
    localparam logic [30:0]        ONE_Q30     = 31'd1073741824;
    localparam logic [30:0]        THR_RESET   = 31'd1074;

    localparam logic [63:0] R_ONE  = 64'd1 << FRAC_W;
    localparam logic [63:0] R_HALF = 64'd1 << (FRAC_W - 1);

    // Q0.48 reciprocals of (2n+2)(2n+3), rounded to nearest
    localparam logic [47:0] RECIP_TAB [RECIP_DEPTH] = '{
        48'((R_ONE + 64'd6    / 64'd2) / 64'd6),
        48'((R_ONE + 64'd20   / 64'd2) / 64'd20),
        48'((R_ONE + 64'd42   / 64'd2) / 64'd42),
        48'((R_ONE + 64'd72   / 64'd2) / 64'd72),
        48'((R_ONE + 64'd110  / 64'd2) / 64'd110),
        48'((R_ONE + 64'd156  / 64'd2) / 64'd156),
        48'((R_ONE + 64'd210  / 64'd2) / 64'd210),
        48'((R_ONE + 64'd272  / 64'd2) / 64'd272),
        48'((R_ONE + 64'd342  / 64'd2) / 64'd342),
        48'((R_ONE + 64'd420  / 64'd2) / 64'd420),
        48'((R_ONE + 64'd506  / 64'd2) / 64'd506),
        48'((R_ONE + 64'd600  / 64'd2) / 64'd600),
        48'((R_ONE + 64'd702  / 64'd2) / 64'd702),
        48'((R_ONE + 64'd812  / 64'd2) / 64'd812),
        48'((R_ONE + 64'd930  / 64'd2) / 64'd930),
        48'((R_ONE + 64'd1056 / 64'd2) / 64'd1056),
        48'((R_ONE + 64'd1190 / 64'd2) / 64'd1190),
        48'((R_ONE + 64'd1332 / 64'd2) / 64'd1332),
        48'((R_ONE + 64'd1482 / 64'd2) / 64'd1482),
        48'((R_ONE + 64'd1640 / 64'd2) / 64'd1640),
        48'((R_ONE + 64'd1806 / 64'd2) / 64'd1806),
        48'((R_ONE + 64'd1980 / 64'd2) / 64'd1980),
        48'((R_ONE + 64'd2162 / 64'd2) / 64'd2162),
        48'((R_ONE + 64'd2352 / 64'd2) / 64'd2352),
        48'((R_ONE + 64'd2550 / 64'd2) / 64'd2550),
        48'((R_ONE + 64'd2756 / 64'd2) / 64'd2756),
        48'((R_ONE + 64'd2970 / 64'd2) / 64'd2970),
        48'((R_ONE + 64'd3192 / 64'd2) / 64'd3192),
        48'((R_ONE + 64'd3422 / 64'd2) / 64'd3422),
        48'((R_ONE + 64'd3660 / 64'd2) / 64'd3660),
        48'((R_ONE + 64'd3906 / 64'd2) / 64'd3906),
        48'((R_ONE + 64'd4160 / 64'd2) / 64'd4160)
    };

endpackage

// File: hdl/tss_mul.sv
// Sequential signed Q.48 multiplier: four 32x32 partial products on one
// multiplier, rounded half away from zero and clamped to 2^62 in magnitude.
// Depends on tss_pkg.
module tss_mul
    import tss_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [63:0] i_a,
    input  logic signed [63:0] i_b,
    output logic               o_done,
    output logic signed [63:0] o_result
);

    localparam logic [2:0] LAST_MUL  = 3'd3;
    localparam logic [2:0] LAST_ACC  = 3'd4;
    localparam logic [2:0] LAST_STEP = 3'd5;
    localparam logic [63:0] MAG_MAX  = 64'd1 << 62;

    logic         r_busy;
    logic         r_done;
    logic [2:0]   r_step;
    logic [63:0]  r_ua;
    logic [63:0]  r_ub;
    logic         r_neg;
    logic [63:0]  r_pp;
    logic [1:0]   r_pp_pos;
    logic [127:0] r_acc;
    logic signed [63:0] r_result;

    logic [31:0]  a_half;
    logic [31:0]  b_half;
    logic [127:0] pp_shifted;
    logic [63:0]  mag;
    logic [63:0]  mag_sat;

    // Pick operand halves: steps 0..3 give a0b0, a0b1, a1b0, a1b1
    assign a_half = r_step[1] ? r_ua[63:32] : r_ua[31:0];
    assign b_half = r_step[0] ? r_ub[63:32] : r_ub[31:0];

    // Align the registered partial product to its column
    always_comb begin
        case (r_pp_pos) inside
            2'd0:       pp_shifted = {64'd0, r_pp};
            2'd1, 2'd2: pp_shifted = {32'd0, r_pp, 32'd0};
            default:    pp_shifted = {r_pp, 64'd0};
        endcase
    end

    // Take the rounded Q.48 magnitude and clamp it
    assign mag     = r_acc[111:48];
    assign mag_sat = (mag > MAG_MAX) ? MAG_MAX : mag;

    // Sequencing control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 3'd1;
                if (r_step == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Operands, partial products and accumulation
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_ua  <= i_a[63] ? (64'd0 - i_a) : i_a;
            r_ub  <= i_b[63] ? (64'd0 - i_b) : i_b;
            r_neg <= i_a[63] ^ i_b[63];
            r_acc <= {64'd0, R_HALF};
        end else if (r_busy) begin
            if (r_step <= LAST_MUL) begin
                r_pp     <= a_half * b_half;
                r_pp_pos <= r_step[1:0];
            end
            if (r_step != 3'd0 && r_step <= LAST_ACC) begin
                r_acc <= r_acc + pp_shifted;
            end
            if (r_step == LAST_STEP) begin
                r_result <= r_neg ? (64'sd0 - $signed(mag_sat)) : $signed(mag_sat);
            end
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

// File: hdl/tss_datapath.sv
// Datapath of the Taylor series sine: angle clip, term and sum registers,
// threshold register, reciprocal lookup, output rounding and registers.
// Depends on tss_pkg and tss_mul.
module tss_datapath
    import tss_pkg::*;
#(
    parameter int MAX_TERMS = 24
)
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [30:0]        i_cfg_wr_data,
    input  logic signed [31:0] i_angle,
    input  t_dp_cmd            i_cmd,
    output t_dp_status         o_status,
    output logic signed [31:0] o_sine_value,
    output logic [4:0]         o_terms_used,
    output logic               o_limit_hit
);

    localparam int CNT_W = $clog2(MAX_TERMS + 1);

    logic [THR_W-1:0]   r_thr;
    logic signed [63:0] r_x;
    logic signed [63:0] r_x2;
    logic signed [63:0] r_term;
    logic signed [63:0] r_sum;
    logic [CNT_W-1:0]   r_cnt;
    logic [IDX_W-1:0]   r_n;
    logic               r_lim;
    logic signed [31:0] r_sine;
    logic [4:0]         r_terms;
    logic               r_lim_out;

    logic signed [31:0] angle_clip;
    logic signed [63:0] mul_a;
    logic signed [63:0] mul_b;
    logic               mul_done;
    logic signed [63:0] mul_res;
    logic [63:0]        term_mag;
    logic [63:0]        thr_q48;
    logic               below;
    logic [CNT_W-1:0]   cnt_next;
    logic               full;
    logic [63:0]        sum_mag;
    logic [63:0]        sum_rnd;
    logic [45:0]        q30;
    logic [30:0]        q30_sat;

    // Clip the angle to +-2*pi
    always_comb begin
        if (i_angle > ANGLE_LIMIT) begin
            angle_clip = ANGLE_LIMIT;
        end else if (i_angle < -ANGLE_LIMIT) begin
            angle_clip = -ANGLE_LIMIT;
        end else begin
            angle_clip = i_angle;
        end
    end

    // Select multiplier operands
    always_comb begin
        unique case (i_cmd.mul_op)
            MOP_SQUARE: begin
                mul_a = r_x;
                mul_b = r_x;
            end
            MOP_XSQ: begin
                mul_a = r_term;
                mul_b = r_x2;
            end
            MOP_RECIP: begin
                mul_a = r_term;
                mul_b = $signed({16'd0, RECIP_TAB[r_n]});
            end
            default: begin
                mul_a = r_term;
                mul_b = r_x2;
            end
        endcase
    end

    tss_mul u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_cmd.mul_start),
        .i_a      (mul_a),
        .i_b      (mul_b),
        .o_done   (mul_done),
        .o_result (mul_res)
    );

    // Stop test: term below threshold, or term count at the limit
    assign term_mag = r_term[63] ? (64'd0 - r_term) : r_term;
    assign thr_q48  = {15'd0, r_thr, 18'd0};
    assign below    = term_mag < thr_q48;
    assign cnt_next = r_cnt + 1'b1;
    assign full     = cnt_next >= CNT_W'(MAX_TERMS);

    assign o_status.mul_done = mul_done;
    assign o_status.stop     = below || full;

    // Round the Q.48 sum to Q2.30 and saturate to one
    assign sum_mag = r_sum[63] ? (64'd0 - r_sum) : r_sum;
    assign sum_rnd = sum_mag + 64'd131072;
    assign q30     = sum_rnd[63:18];
    assign q30_sat = (q30 > {15'd0, ONE_Q30}) ? ONE_Q30 : q30[30:0];

    // Hold the threshold register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (i_cfg_wr_en) begin
            r_thr <= i_cfg_wr_data;
        end
    end

    // Working registers of the series
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x    <= {{12{angle_clip[31]}}, angle_clip, 20'd0};
            r_term <= {{12{angle_clip[31]}}, angle_clip, 20'd0};
            r_sum  <= '0;
            r_cnt  <= '0;
            r_n    <= '0;
        end else begin
            if (i_cmd.wr_x2) begin
                r_x2 <= mul_res;
            end
            if (i_cmd.wr_term) begin
                r_term <= mul_res;
            end
            if (i_cmd.adv_n) begin
                r_n <= r_n + 1'b1;
            end
            if (i_cmd.accum) begin
                r_sum <= r_n[0] ? (r_sum - r_term) : (r_sum + r_term);
                r_cnt <= cnt_next;
                r_lim <= !below && full;
            end
        end
    end

    // Output registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_sine    <= r_sum[63] ? (32'sd0 - $signed({1'b0, q30_sat}))
                                   : $signed({1'b0, q30_sat});
            r_terms   <= 5'(r_cnt);
            r_lim_out <= r_lim;
        end
    end

    assign o_sine_value = r_sine;
    assign o_terms_used = r_terms;
    assign o_limit_hit  = r_lim_out;

endmodule

// File: hdl/tss_ctrl.sv
// Controller of the Taylor series sine: sequences squaring, term updates and
// accumulation, and owns the channel handshakes. Depends on tss_pkg.
module tss_ctrl
    import tss_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    // State and output-valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and datapath commands
    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_cmd.mul_op = MOP_SQUARE;
        o_in_ready   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SQ_START;
                end
            end
            S_SQ_START: begin
                o_cmd.mul_start = 1'b1;
                o_cmd.mul_op    = MOP_SQUARE;
                n_state         = S_SQ_WAIT;
            end
            S_SQ_WAIT: begin
                if (i_status.mul_done) begin
                    o_cmd.wr_x2 = 1'b1;
                    n_state     = S_ACCUM;
                end
            end
            S_ACCUM: begin
                o_cmd.accum = 1'b1;
                n_state     = i_status.stop ? S_FINISH : S_M1_START;
            end
            S_M1_START: begin
                o_cmd.mul_start = 1'b1;
                o_cmd.mul_op    = MOP_XSQ;
                n_state         = S_M1_WAIT;
            end
            S_M1_WAIT: begin
                if (i_status.mul_done) begin
                    o_cmd.wr_term = 1'b1;
                    n_state       = S_M2_START;
                end
            end
            S_M2_START: begin
                o_cmd.mul_start = 1'b1;
                o_cmd.mul_op    = MOP_RECIP;
                n_state         = S_M2_WAIT;
            end
            S_M2_WAIT: begin
                if (i_status.mul_done) begin
                    o_cmd.wr_term = 1'b1;
                    o_cmd.adv_n   = 1'b1;
                    n_state       = S_ACCUM;
                end
            end
            S_FINISH: begin
                // Wait until the output register is free or being drained
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output transaction: set on finish, drop when taken
    always_comb begin
        if (o_cmd.finish) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// File: hdl/taylor_series_sine.sv
// Taylor series sine, signed Q4.28 angle in, signed Q2.30 sine out.
//
// Input channel: i_valid/o_ready with i_angle. One transaction is taken
// when both are high; o_ready is high only while no angle is in work.
// Output channel: o_valid/i_ready with o_sine_value, o_terms_used and
// o_limit_hit, held in an output register until the receiver takes them.
// A new angle may be accepted while the previous result still waits.
// Configuration: i_cfg_wr_en writes i_cfg_wr_data into the stop threshold
// (Q2.30 term magnitude) at the clock edge; write only while idle.
// Each term costs two Q.48 products on one shared 32x32 multiplier, each
// product four partial products plus accumulate, round and sign steps,
// and one accumulate step.
// If the receiver stalls, the finished sum waits in the datapath until the
// output register frees up.
// Reset (i_rst_n low, synchronous) returns to idle, clears o_valid and sets
// the threshold to 1074 (about 1e-6).
// Depends on tss_pkg, tss_ctrl, tss_datapath and tss_mul.
module taylor_series_sine
    import tss_pkg::*;
#(
    parameter int MAX_TERMS = 24
)
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [30:0]        i_cfg_wr_data,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [31:0] i_angle,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_sine_value,
    output logic [4:0]         o_terms_used,
    output logic               o_limit_hit
);

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    tss_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .o_in_ready  (o_ready),
        .o_out_valid (o_valid),
        .i_out_ready (i_ready),
        .i_status    (dp_status),
        .o_cmd       (dp_cmd)
    );

    tss_datapath #(
        .MAX_TERMS (MAX_TERMS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_angle       (i_angle),
        .i_cmd         (dp_cmd),
        .o_status      (dp_status),
        .o_sine_value  (o_sine_value),
        .o_terms_used  (o_terms_used),
        .o_limit_hit   (o_limit_hit)
    );

endmodule
